// ===== rtl/atig_pkg.sv =====
// Package with the mode codes, constants and state types of the arpeggio index generator.
`default_nettype none
package atig_pkg;

	localparam int MAX_POOL = 16;
	localparam int MAX_ATTEMPTS = 64;

	localparam logic [3:0] MODE_UP       = 4'd0;
	localparam logic [3:0] MODE_DOWN     = 4'd1;
	localparam logic [3:0] MODE_UPDOWN_I = 4'd2;
	localparam logic [3:0] MODE_UPDOWN_X = 4'd3;
	localparam logic [3:0] MODE_CONVERGE = 4'd4;
	localparam logic [3:0] MODE_DIVERGE  = 4'd5;
	localparam logic [3:0] MODE_OUTSIDE  = 4'd6;
	localparam logic [3:0] MODE_SPIRAL   = 4'd7;
	localparam logic [3:0] MODE_WALK     = 4'd8;
	localparam logic [3:0] MODE_RANDOM   = 4'd9;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_POOL = 2'd1;
	localparam logic [1:0] REG_SEED = 2'd2;

	localparam logic [63:0] WALK_SALT   = 64'h5741;
	localparam logic [63:0] RANDOM_SALT = 64'h9E37;
	localparam logic [63:0] MIX_GAMMA   = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL1    = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL2    = 64'h94D049BB133111EB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_CHECK,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [3:0] {
		MX_IDLE,
		MX_X1,
		MX_M0,
		MX_M1,
		MX_M2,
		MX_M3,
		MX_X2,
		MX_X3,
		MX_DONE
	} mix_state_t;

endpackage
`default_nettype wire

// ===== rtl/atig_mix.sv =====
// Iterative splitmix64 finalizer built around one shared 32 by 32 multiplier.
`default_nettype none
module atig_mix (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] x,
	output logic             done,
	output logic [63:0]      z
);

	atig_pkg::mix_state_t state_q, state_d;
	logic [63:0] z_q;
	logic [63:0] opa_q;
	logic [63:0] prod_q;
	logic        round_q;
	logic [63:0] mul_b;
	logic [31:0] op_x;
	logic [31:0] op_y;

	assign mul_b = round_q ? atig_pkg::MIX_MUL2 : atig_pkg::MIX_MUL1;
	assign op_x  = (state_q == atig_pkg::MX_M2) ? opa_q[63:32] : opa_q[31:0];
	assign op_y  = (state_q == atig_pkg::MX_M1) ? mul_b[63:32] : mul_b[31:0];
	assign done  = (state_q == atig_pkg::MX_DONE);
	assign z     = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atig_pkg::MX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			atig_pkg::MX_IDLE: if (start) state_d = atig_pkg::MX_X1;
			atig_pkg::MX_X1:   state_d = atig_pkg::MX_M0;
			atig_pkg::MX_M0:   state_d = atig_pkg::MX_M1;
			atig_pkg::MX_M1:   state_d = atig_pkg::MX_M2;
			atig_pkg::MX_M2:   state_d = atig_pkg::MX_M3;
			atig_pkg::MX_M3:   state_d = round_q ? atig_pkg::MX_X3 : atig_pkg::MX_X2;
			atig_pkg::MX_X2:   state_d = atig_pkg::MX_M0;
			atig_pkg::MX_X3:   state_d = atig_pkg::MX_DONE;
			atig_pkg::MX_DONE: state_d = atig_pkg::MX_IDLE;
			default:           state_d = atig_pkg::MX_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= {32'b0, op_x} * {32'b0, op_y};
		unique case (state_q)
			atig_pkg::MX_IDLE: if (start) z_q <= x + atig_pkg::MIX_GAMMA;
			atig_pkg::MX_X1: begin
				opa_q   <= z_q ^ (z_q >> 30);
				round_q <= 1'b0;
			end
			atig_pkg::MX_M1: z_q <= prod_q;
			atig_pkg::MX_M2: z_q <= z_q + {prod_q[31:0], 32'b0};
			atig_pkg::MX_M3: z_q <= z_q + {prod_q[31:0], 32'b0};
			atig_pkg::MX_X2: begin
				opa_q   <= z_q ^ (z_q >> 27);
				round_q <= 1'b1;
			end
			atig_pkg::MX_X3: z_q <= z_q ^ (z_q >> 31);
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/arpeggio_traversal_index_generator.sv =====
// Top level of the arpeggio traversal index generator.
//
//   channel   dir  beat contents
//   s_*       in   tdata[0] restart
//   m_*       out  tdata[3:0] note_index, tdata[9:4] step_position, tlast period_last
//   cfg_*     in   write of direction_mode, pool_size or random_seed
//
// Fixed modes need no hash or remainder pass. Spiral runs through the 4-bit-per-cycle
// remainder unit. Walk needs one hash pass, and random needs one hash plus remainder
// per rejection attempt, up to MAX_ATTEMPTS attempts. Reset clears the control and
// traversal state asynchronously. A result waits in the output register while the
// next tick is taken.
`default_nettype none
module arpeggio_traversal_index_generator #(
	parameter int MAX_ATTEMPTS = atig_pkg::MAX_ATTEMPTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // note_index, step_position
	output logic             m_tlast,   // period_last
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int AW = $clog2(MAX_ATTEMPTS + 1);

	function automatic logic [6:0] conv_idx(input logic [6:0] n, input logic [6:0] k);
		return k[0] ? (n - 7'd1 - (k >> 1)) : (k >> 1);
	endfunction

	function automatic logic [3:0] entry_fixed(input logic [3:0] mode, input logic [6:0] n,
		input logic [6:0] k);
		logic [6:0] r;
		begin
			unique case (mode)
				atig_pkg::MODE_DOWN:     r = n - 7'd1 - k;
				atig_pkg::MODE_UPDOWN_I: r = (k < n) ? k : (7'd2 * n - 7'd1 - k);
				atig_pkg::MODE_UPDOWN_X: r = (k < n) ? k : (7'd2 * n - 7'd2 - k);
				atig_pkg::MODE_CONVERGE: r = conv_idx(n, k);
				atig_pkg::MODE_DIVERGE:  r = conv_idx(n, n - 7'd1 - k);
				atig_pkg::MODE_OUTSIDE:
					r = (k < n) ? conv_idx(n, k) : conv_idx(n, 7'd2 * n - 7'd1 - k);
				atig_pkg::MODE_WALK:     r = n >> 1;
				default:                 r = k;
			endcase
			if (n == 7'd1) r = 7'd0;
			return r[3:0];
		end
	endfunction

	function automatic logic [6:0] period_of(input logic [3:0] mode, input logic [6:0] n);
		logic [6:0] p;
		begin
			unique case (mode)
				atig_pkg::MODE_UPDOWN_I, atig_pkg::MODE_OUTSIDE: p = 7'd2 * n;
				atig_pkg::MODE_UPDOWN_X: p = 7'd2 * n - 7'd2;
				atig_pkg::MODE_SPIRAL:   p = 7'd3 * n;
				atig_pkg::MODE_WALK, atig_pkg::MODE_RANDOM: p = 7'd4 * n;
				default:                 p = n;
			endcase
			if (n == 7'd1) p = 7'd1;
			return p;
		end
	endfunction

	atig_pkg::seq_state_t state_q, state_d;

	logic [3:0]    mode_q;
	logic [4:0]    pool_q;
	logic [63:0]   seed_q;
	logic [5:0]    pos_q;
	logic [3:0]    cur_q;
	logic [3:0]    first_q;
	logic [5:0]    k_q;
	logic [3:0]    res_q;
	logic [AW-1:0] att_q;
	logic [4:0]    rem_q;
	logic [63:0]   modv_q;
	logic [3:0]    cnt_q;

	logic [4:0]    n5;
	logic [6:0]    n7;
	logic [6:0]    period;
	logic          accept;
	logic          restart;
	logic [5:0]    pos_eff;
	logic [5:0]    k_in;
	logic [11:0]   k43;
	logic [4:0]    q3;
	logic [4:0]    spiral_s;
	logic          last_k;
	logic          cand_ok;
	logic [3:0]    fallback;
	logic          found;
	logic [4:0]    prev_inc;
	logic [4:0]    rem_next;
	logic [5:0]    rstep;
	logic          hash_start;
	logic [5:0]    hk;
	logic [AW-1:0] ha;
	logic [63:0]   hash_x;
	logic          hash_done;
	logic [63:0]   hash_z;
	logic          out_free;
	logic [3:0]    walk_note;
	logic [4:0]    cur_p1;
	logic          cfg_clear;

	assign n5      = (pool_q > 5'(atig_pkg::MAX_POOL)) ? 5'(atig_pkg::MAX_POOL) : pool_q;
	assign n7      = {2'b0, n5};
	assign period  = period_of(mode_q, n7);
	assign accept  = s_tvalid && s_tready;
	assign restart = s_tdata[0];
	assign pos_eff = restart ? 6'd0 : pos_q;
	assign k_in    = ({1'b0, pos_eff} >= period) ? 6'd0 : pos_eff;
	assign s_tready = (state_q == atig_pkg::ST_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign cfg_clear = cfg_we && (cfg_index == atig_pkg::REG_MODE ||
		cfg_index == atig_pkg::REG_POOL || cfg_index == atig_pkg::REG_SEED);

	assign k43      = {6'b0, k_in} * 12'd43;
	assign q3       = k43[11:7];
	assign spiral_s = q3 + 5'(k_in - 6'(3 * q3));

	assign last_k  = ({1'b0, k_q} == period - 7'd1);
	assign cand_ok = (k_q == 6'd0) ||
		((rem_q[3:0] != cur_q) && !(last_k && (rem_q[3:0] == first_q)));
	assign prev_inc = {1'b0, cur_q} + 5'd1;

	always_comb begin
		fallback = (prev_inc == n5) ? 4'd0 : prev_inc[3:0];
		found = 1'b0;
		for (int c = 0; c < atig_pkg::MAX_POOL; c++) begin
			if (!found && (5'(c) < n5) && (4'(c) != cur_q) &&
				!(last_k && (4'(c) == first_q))) begin
				fallback = 4'(c);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		rstep = 6'd0;
		rem_next = rem_q;
		for (int b = 0; b < 4; b++) begin
			rstep = {rem_next, modv_q[63 - b]};
			if (rstep >= {1'b0, n5}) rstep = rstep - {1'b0, n5};
			rem_next = rstep[4:0];
		end
	end

	assign cur_p1    = {1'b0, cur_q} + 5'd1;
	assign walk_note = hash_z[0] ?
		((cur_p1 > n5 - 5'd1) ? 4'(n5 - 5'd2) : cur_p1[3:0]) :
		((cur_q == 4'd0) ? 4'd1 : cur_q - 4'd1);

	assign hk = (state_q == atig_pkg::ST_IDLE) ? k_in : k_q;
	assign ha = (state_q == atig_pkg::ST_IDLE) ? '0 : att_q + AW'(1);
	assign hash_x = (mode_q == atig_pkg::MODE_WALK) ?
		(seed_q ^ atig_pkg::WALK_SALT ^ {58'b0, hk}) :
		(seed_q ^ atig_pkg::RANDOM_SALT ^ {58'b0, hk} ^ ({{(64 - AW){1'b0}}, ha} << 32));

	atig_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.x      (hash_x),
		.done   (hash_done),
		.z      (hash_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atig_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		hash_start = 1'b0;
		unique case (state_q)
			atig_pkg::ST_IDLE: begin
				if (accept && (n5 != 5'd0)) begin
					if (n5 == 5'd1) begin
						state_d = atig_pkg::ST_EMIT;
					end else if (mode_q == atig_pkg::MODE_SPIRAL) begin
						state_d = atig_pkg::ST_MOD;
					end else if (mode_q == atig_pkg::MODE_RANDOM ||
						(mode_q == atig_pkg::MODE_WALK && k_in != 6'd0)) begin
						state_d    = atig_pkg::ST_HASH;
						hash_start = 1'b1;
					end else begin
						state_d = atig_pkg::ST_EMIT;
					end
				end
			end
			atig_pkg::ST_HASH: begin
				if (hash_done) begin
					state_d = (mode_q == atig_pkg::MODE_WALK) ? atig_pkg::ST_EMIT :
						atig_pkg::ST_MOD;
				end
			end
			atig_pkg::ST_MOD: if (cnt_q == 4'd15) state_d = atig_pkg::ST_CHECK;
			atig_pkg::ST_CHECK: begin
				if (mode_q == atig_pkg::MODE_SPIRAL || cand_ok ||
					att_q == AW'(MAX_ATTEMPTS - 1)) begin
					state_d = atig_pkg::ST_EMIT;
				end else begin
					state_d    = atig_pkg::ST_HASH;
					hash_start = 1'b1;
				end
			end
			atig_pkg::ST_EMIT: if (out_free) state_d = atig_pkg::ST_IDLE;
			default: state_d = atig_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= atig_pkg::MODE_UP;
			pool_q   <= 5'd0;
			seed_q   <= 64'd0;
			pos_q    <= 6'd0;
			cur_q    <= 4'd0;
			first_q  <= 4'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					atig_pkg::REG_MODE: mode_q <= cfg_data[3:0];
					atig_pkg::REG_POOL: pool_q <= cfg_data[4:0];
					atig_pkg::REG_SEED: seed_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == atig_pkg::ST_EMIT && out_free) begin
				m_tvalid <= 1'b1;
				cur_q    <= res_q;
				if (k_q == 6'd0) first_q <= res_q;
				pos_q    <= ({1'b0, k_q} + 7'd1 >= period) ? 6'd0 : k_q + 6'd1;
			end else begin
				if (m_tready) m_tvalid <= 1'b0;
				if (cfg_clear || (state_q == atig_pkg::ST_IDLE && accept && restart))
					pos_q <= 6'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			atig_pkg::ST_IDLE: begin
				k_q    <= k_in;
				res_q  <= entry_fixed(mode_q, n7, {1'b0, k_in});
				att_q  <= '0;
				rem_q  <= 5'd0;
				cnt_q  <= 4'd0;
				modv_q <= {59'b0, spiral_s};
			end
			atig_pkg::ST_HASH: begin
				rem_q  <= 5'd0;
				cnt_q  <= 4'd0;
				modv_q <= hash_z;
				if (hash_done) res_q <= walk_note;
			end
			atig_pkg::ST_MOD: begin
				rem_q  <= rem_next;
				modv_q <= modv_q << 4;
				cnt_q  <= cnt_q + 4'd1;
			end
			atig_pkg::ST_CHECK: begin
				if (mode_q == atig_pkg::MODE_SPIRAL || cand_ok) begin
					res_q <= rem_q[3:0];
				end else if (att_q == AW'(MAX_ATTEMPTS - 1)) begin
					res_q <= fallback;
				end else begin
					att_q <= att_q + AW'(1);
				end
			end
			atig_pkg::ST_EMIT: begin
				if (out_free) begin
					m_tdata <= {6'b0, k_q, res_q};
					m_tlast <= last_k;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
